### hdl/mqss_pkg.sv
// Package for the multilevel queue sweep scheduler.
// Holds sizes, codes, state types and the priority unit's request/response structs.
// No dependencies.
package mqss_pkg;

  localparam int NUM_QUEUES   = 128;
  localparam int POOL_ENTRIES = 1024;

  localparam int QW  = $clog2(NUM_QUEUES);    // queue index width
  localparam int PW  = $clog2(POOL_ENTRIES);  // handle width
  localparam int SW  = QW + 2;                // signed sweep counters
  localparam int CW  = 16;                    // coefficient width
  localparam int MPW = 8;                     // move priority width
  localparam int NW  = 6;                     // progress count width
  localparam int CFG_IW = 2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_COEF_SQUARE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_COEF_LINEAR = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_COEF_OFFSET = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_STACK_MODE  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_PRI, S_LINK, S_SWEEP, S_POP1, S_POP2, S_TOP, S_DONE
  } sched_state_e;

  typedef enum logic [1:0] {
    PH_IDLE, PH_MUL2, PH_ROUND, PH_DONE
  } prio_phase_e;

  typedef struct packed {
    logic                  start;
    logic [NW-1:0]         n;
    logic signed [MPW-1:0] move_priority;
  } prio_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] queue;
  } prio_rsp_t;

endpackage

### hdl/mqss_intf.sv
// Channel interfaces: work items, results and configuration writes.
// Depends on mqss_pkg.
interface mqss_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [9:0]                            item_handle;
  logic signed [mqss_pkg::MPW-1:0]       move_priority;
  logic [mqss_pkg::NW-1:0]               cards_out;
  modport source(output valid, operation, item_handle, move_priority, cards_out, input ready);
  modport sink(input valid, operation, item_handle, move_priority, cards_out, output ready);
endinterface

interface mqss_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [9:0] out_handle;
  logic [6:0] queue_index;
  modport source(output valid, found, out_handle, queue_index, input ready);
  modport sink(input valid, found, out_handle, queue_index, output ready);
endinterface

interface mqss_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mqss_pkg::CFG_IW-1:0]      index;
  logic [mqss_pkg::CW-1:0]          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/mqss_prio_unit.sv
// Priority unit: one shared multiply-accumulate evaluates (a*n + b)*n + c over two
// passes, then rounds and clamps to a queue index. Depends on mqss_pkg.
module mqss_prio_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [mqss_pkg::CW-1:0]  coef_square_i,
  input  logic signed [mqss_pkg::CW-1:0]  coef_linear_i,
  input  logic signed [mqss_pkg::CW-1:0]  coef_offset_i,
  input  mqss_pkg::prio_req_t             req_i,
  output mqss_pkg::prio_rsp_t             rsp_o
);
  import mqss_pkg::*;

  localparam int AW = CW + NW + 2;   // first-pass accumulator width
  localparam int XW = AW + NW + 2;   // full accumulator width
  localparam int BW = XW - 8;        // bonus width
  localparam int RW = BW + 1;        // priority sum width

  prio_phase_e phase_q, phase_d;
  logic signed [XW-1:0]  acc_q, acc_d;
  logic [NW-1:0]         n_q, n_d;
  logic signed [MPW-1:0] mp_q, mp_d;
  logic [QW-1:0]         queue_q, queue_d;

  logic signed [AW-1:0]   mul_a;
  logic signed [NW:0]     mul_n;
  logic signed [CW-1:0]   addend;
  logic signed [AW+NW:0]  prod;
  logic signed [XW-1:0]   sum;
  logic signed [XW-1:0]   rsum;
  logic signed [BW-1:0]   bonus;
  logic signed [RW-1:0]   pri;

  // shared multiply-accumulate
  always_comb begin
    if (phase_q == PH_MUL2) begin
      mul_a  = acc_q[AW-1:0];
      mul_n  = $signed({1'b0, n_q});
      addend = coef_offset_i;
    end else begin
      mul_a  = AW'(coef_square_i);
      mul_n  = $signed({1'b0, req_i.n});
      addend = coef_linear_i;
    end
    prod = mul_a * mul_n;
    sum  = XW'(prod) + XW'(addend);
  end

  // round half up in Q8.8, then add and saturate
  always_comb begin
    rsum  = acc_q + XW'(128);
    bonus = rsum[XW-1:8];
    pri   = RW'(mp_q) + RW'(bonus);
  end

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE:  if (req_i.start) phase_d = PH_MUL2;
      PH_MUL2:  phase_d = PH_ROUND;
      PH_ROUND: phase_d = PH_DONE;
      PH_DONE:  phase_d = PH_IDLE;
      default:  phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    acc_d   = acc_q;
    n_d     = n_q;
    mp_d    = mp_q;
    queue_d = queue_q;
    case (phase_q)
      PH_IDLE: begin
        if (req_i.start) begin
          acc_d = sum;
          n_d   = req_i.n;
          mp_d  = req_i.move_priority;
        end
      end
      PH_MUL2: acc_d = sum;
      PH_ROUND: begin
        if (pri < 0) begin
          queue_d = '0;
        end else if (pri > RW'(NUM_QUEUES - 1)) begin
          queue_d = QW'(NUM_QUEUES - 1);
        end else begin
          queue_d = pri[QW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    n_q     <= n_d;
    mp_q    <= mp_d;
    queue_q <= queue_d;
  end

  assign rsp_o.done  = (phase_q == PH_DONE);
  assign rsp_o.queue = queue_q;

endmodule

### hdl/multilevel_queue_sweep_scheduler_unit.sv
// Top level of the multilevel queue sweep scheduler: sequencer, queue memories, sweep.
// Depends on mqss_pkg, mqss_intf and mqss_prio_unit.
//
// Channel   Dir  Moves                                        Transfer when
// in_chan   in   operation, item_handle, move_priority, n     valid & ready
// res_chan  out  found, out_handle, queue_index               valid & ready
// cfg_chan  in   index, data (coefficients, stack mode)       valid & ready (ready tied high)
//
// Enqueue: the result follows the two multiply passes, the round, the queue handoff, the link
// and the load into the output register; the link is skipped when the target queue was empty.
// Dequeue: the sweep steps down to a hit, the pop steps read and unlink its head, the top mark
// is lowered past emptied top queues, and the result loads; an empty sweep goes straight to the load.
// Input is ready again the cycle after the result loads into the output register.
// Reset clears the head valid bits, marks and coefficients; no clearing pass.
// A result waiting in the output register stalls only the finish of the next item.
module multilevel_queue_sweep_scheduler_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  mqss_in_if.sink   in_chan_i,
  mqss_out_if.source res_chan_o,
  mqss_cfg_if.sink  cfg_chan_i
);
  import mqss_pkg::*;

  localparam logic signed [SW-1:0] NQ_S = SW'(NUM_QUEUES);

  sched_state_e state_q, state_d;

  // configuration
  logic signed [CW-1:0] coef_square_q, coef_linear_q, coef_offset_q;
  logic                 stack_q;

  // scheduler marks
  logic [QW-1:0]        top_q, top_d;
  logic signed [SW-1:0] pos_q, pos_d, floor_q, floor_d;
  logic                 last_q, last_d;
  logic [NUM_QUEUES-1:0] hvalid_q;

  // item context
  logic [QW-1:0] q_q, q_d;
  logic [PW-1:0] h_q, h_d;
  logic          res_found_q, res_found_d;
  logic [PW-1:0] res_handle_q, res_handle_d;
  logic [QW-1:0] res_queue_q, res_queue_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          out_found_q;
  logic [PW-1:0] out_handle_q;
  logic [QW-1:0] out_queue_q;
  logic          out_load;

  // memories: list heads, list tails, per-handle links (valid + handle)
  logic [PW-1:0] head_mem [NUM_QUEUES];
  logic [PW-1:0] tail_mem [NUM_QUEUES];
  logic [PW:0]   next_mem [POOL_ENTRIES];
  logic [PW-1:0] head_rd_q, tail_rd_q;
  logic [PW:0]   next_rd_q;

  logic          head_we, tail_we, next_we, hv_we, hv_val;
  logic [QW-1:0] head_waddr, head_raddr, tail_waddr, tail_raddr, hv_addr;
  logic [PW-1:0] head_wdata, tail_wdata, next_waddr, next_raddr;
  logic [PW:0]   next_wdata;

  prio_req_t prio_req;
  prio_rsp_t prio_rsp;

  logic in_xfer, out_free;

  // sweep step
  logic signed [SW-1:0] top_s, sw_pos, sw_floor, pos_m1;
  logic                 sw_last, sw_empty, sw_hit, top_lower, pq_valid;

  assign in_xfer  = in_chan_i.valid && in_chan_i.ready;
  assign out_free = !out_valid_q || res_chan_o.ready;
  assign top_s    = SW'(top_q);
  assign pos_m1   = pos_q - SW'(1);
  assign pq_valid = hvalid_q[prio_rsp.queue];

  mqss_prio_unit u_prio (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coef_square_i(coef_square_q),
    .coef_linear_i(coef_linear_q),
    .coef_offset_i(coef_offset_q),
    .req_i        (prio_req),
    .rsp_o        (prio_rsp)
  );

  // one step of the widening downward sweep
  always_comb begin
    sw_pos   = pos_m1;
    sw_floor = floor_q;
    sw_last  = last_q;
    sw_empty = 1'b0;
    if (sw_pos < sw_floor) begin
      if (last_q) begin
        sw_empty = 1'b1;
      end else begin
        sw_pos   = top_s;
        sw_floor = floor_q - SW'(1);
        if (sw_floor < 0) sw_floor = top_s;
        if (sw_floor <= 0) sw_last = 1'b1;
      end
    end
    sw_hit = !sw_empty && (sw_pos >= 0) && (sw_pos < NQ_S) && hvalid_q[sw_pos[QW-1:0]];
  end

  // lower the top mark past a queue the pop left empty
  always_comb begin
    top_lower = !((pos_q >= 0) && (pos_q < NQ_S) && hvalid_q[pos_q[QW-1:0]]) &&
                (pos_q == top_s) && (top_q != '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) state_d = (in_chan_i.operation == OP_DEQUEUE) ? S_SWEEP : S_PRI;
      S_PRI:   if (prio_rsp.done) state_d = pq_valid ? S_LINK : S_DONE;
      S_LINK:  state_d = S_DONE;
      S_SWEEP: begin
        if (sw_empty) begin
          state_d = S_DONE;
        end else if (sw_hit) begin
          state_d = S_POP1;
        end
      end
      S_POP1:  state_d = S_POP2;
      S_POP2:  state_d = S_TOP;
      S_TOP:   if (!top_lower) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    top_d        = top_q;
    pos_d        = pos_q;
    floor_d      = floor_q;
    last_d       = last_q;
    q_d          = q_q;
    h_d          = h_q;
    res_found_d  = res_found_q;
    res_handle_d = res_handle_q;
    res_queue_d  = res_queue_q;
    out_load     = 1'b0;
    prio_req.start         = 1'b0;
    prio_req.n             = in_chan_i.cards_out;
    prio_req.move_priority = in_chan_i.move_priority;
    head_we = 1'b0; head_waddr = q_q; head_wdata = h_q; head_raddr = q_q;
    tail_we = 1'b0; tail_waddr = q_q; tail_wdata = h_q; tail_raddr = q_q;
    next_we = 1'b0; next_waddr = h_q; next_wdata = '0;  next_raddr = head_rd_q;
    hv_we   = 1'b0; hv_addr    = q_q; hv_val     = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          h_d    = in_chan_i.item_handle[PW-1:0];
          last_d = 1'b0;
          prio_req.start = (in_chan_i.operation == OP_ENQUEUE);
        end
      end
      S_PRI: begin
        head_raddr = prio_rsp.queue;
        tail_raddr = prio_rsp.queue;
        if (prio_rsp.done) begin
          q_d = prio_rsp.queue;
          if (prio_rsp.queue > top_q) top_d = prio_rsp.queue;
          next_we      = 1'b1;
          res_found_d  = 1'b1;
          res_handle_d = '0;
          res_queue_d  = prio_rsp.queue;
          if (!pq_valid) begin
            head_we = 1'b1; head_waddr = prio_rsp.queue;
            tail_we = 1'b1; tail_waddr = prio_rsp.queue;
            hv_we   = 1'b1; hv_addr    = prio_rsp.queue;
          end
        end
      end
      S_LINK: begin
        if (stack_q) begin
          next_we    = 1'b1;
          next_wdata = {1'b1, head_rd_q};
          head_we    = 1'b1;
        end else begin
          next_we    = 1'b1;
          next_waddr = tail_rd_q;
          next_wdata = {1'b1, h_q};
          tail_we    = 1'b1;
        end
      end
      S_SWEEP: begin
        pos_d      = sw_pos;
        floor_d    = sw_floor;
        last_d     = sw_last;
        head_raddr = sw_pos[QW-1:0];
        if (sw_empty) begin
          res_found_d  = 1'b0;
          res_handle_d = '0;
          res_queue_d  = '0;
        end
      end
      S_POP1: begin
        res_found_d  = 1'b1;
        res_handle_d = head_rd_q;
        res_queue_d  = pos_q[QW-1:0];
      end
      S_POP2: begin
        head_we    = 1'b1;
        head_waddr = pos_q[QW-1:0];
        head_wdata = next_rd_q[PW-1:0];
        hv_we      = 1'b1;
        hv_addr    = pos_q[QW-1:0];
        hv_val     = next_rd_q[PW];
      end
      S_TOP: begin
        if (top_lower) begin
          top_d = top_q - QW'(1);
          pos_d = pos_m1;
          if (pos_m1 < floor_q) floor_d = pos_m1;
        end
      end
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && res_chan_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      coef_square_q <= '0;
      coef_linear_q <= '0;
      coef_offset_q <= '0;
      stack_q       <= 1'b0;
      top_q         <= '0;
      pos_q         <= '0;
      floor_q       <= '0;
      last_q        <= 1'b0;
      hvalid_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      pos_q       <= pos_d;
      floor_q     <= floor_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (hv_we) hvalid_q[hv_addr] <= hv_val;
      if (cfg_chan_i.valid) begin
        case (cfg_chan_i.index)
          CFG_COEF_SQUARE: coef_square_q <= cfg_chan_i.data;
          CFG_COEF_LINEAR: coef_linear_q <= cfg_chan_i.data;
          CFG_COEF_OFFSET: coef_offset_q <= cfg_chan_i.data;
          CFG_STACK_MODE:  stack_q       <= cfg_chan_i.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q          <= q_d;
    h_q          <= h_d;
    res_found_q  <= res_found_d;
    res_handle_q <= res_handle_d;
    res_queue_q  <= res_queue_d;
    if (out_load) begin
      out_found_q  <= res_found_q;
      out_handle_q <= res_handle_q;
      out_queue_q  <= res_queue_q;
    end
  end

  // queue memories, registered read
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rd_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) tail_mem[tail_waddr] <= tail_wdata;
    tail_rd_q <= tail_mem[tail_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rd_q <= next_mem[next_raddr];
  end

  assign in_chan_i.ready        = (state_q == S_IDLE);
  assign cfg_chan_i.ready       = 1'b1;
  assign res_chan_o.valid       = out_valid_q;
  assign res_chan_o.found       = out_found_q;
  assign res_chan_o.out_handle  = out_handle_q;
  assign res_chan_o.queue_index = out_queue_q;

endmodule

### dv/tb_top.sv
// Self-checking bench for multilevel_queue_sweep_scheduler_unit: random and directed work items
// checked against an in-bench priority/sweep predictor held in a small scoreboard class.
// Depends on mqss_pkg, mqss_intf and the scheduler RTL.
`timescale 1ns / 100ps

module tb_top;
  import mqss_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SHOW_MAX    = 10;

  typedef struct {
    logic          found;
    logic [PW-1:0] handle;
    logic [QW-1:0] queue;
  } sched_result_t;

  // Scoreboard: predicts each result from the transfers seen on the work channel.
  class sched_scoreboard;
    logic [PW:0]   head_q[NUM_QUEUES];   // bit PW is the valid flag
    logic [PW-1:0] tail_q[NUM_QUEUES];
    logic [PW:0]   next_h[POOL_ENTRIES];
    int            top_q, sweep_pos, sweep_flr;
    int            k_sq, k_lin, k_off;
    bit            lifo;
    sched_result_t due_q[$];
    int            mismatches;

    function void clear();
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] = '0;
        tail_q[i] = '0;
      end
      for (int i = 0; i < POOL_ENTRIES; i++) next_h[i] = '0;
      top_q = 0; sweep_pos = 0; sweep_flr = 0;
      k_sq = 0; k_lin = 0; k_off = 0; lifo = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] data);
      case (idx)
        CFG_COEF_SQUARE: k_sq  = $signed(data);
        CFG_COEF_LINEAR: k_lin = $signed(data);
        CFG_COEF_OFFSET: k_off = $signed(data);
        CFG_STACK_MODE:  lifo  = data[0];
        default: ;
      endcase
    endfunction

    function bit busy_queue(int q);
      if (q < 0 || q >= NUM_QUEUES) return 0;
      return head_q[q][PW];
    endfunction

    // Q8.8 quadratic, rounded half up (floor of x/256 + 1/2)
    function longint bonus(longint n);
      longint x;
      x = (longint'(k_sq) * n + k_lin) * n + k_off;
      return (x + 128) >>> 8;
    endfunction

    function void note_item(logic op, logic [PW-1:0] h, logic signed [MPW-1:0] mp,
                            logic [NW-1:0] n);
      sched_result_t r;
      longint        pri;
      int            q;
      bit            last;
      if (op == OP_ENQUEUE) begin
        pri = longint'(mp) + bonus(longint'(n));
        if (pri < 0) pri = 0;
        else if (pri >= NUM_QUEUES) pri = NUM_QUEUES - 1;
        q = int'(pri);
        if (q > top_q) top_q = q;
        next_h[h] = '0;
        if (!head_q[q][PW]) begin
          head_q[q] = {1'b1, h};
          tail_q[q] = h;
        end else if (lifo) begin
          next_h[h] = head_q[q];
          head_q[q] = {1'b1, h};
        end else begin
          next_h[tail_q[q]] = {1'b1, h};
          tail_q[q] = h;
        end
        r.found = 1'b1; r.handle = '0; r.queue = q[QW-1:0];
        due_q.push_back(r);
        return;
      end
      // widening downward sweep; each restart drops the floor by one, wrapping to the top mark below zero
      last = 0;
      forever begin
        sweep_pos--;
        if (sweep_pos < sweep_flr) begin
          if (last) begin
            r.found = 1'b0; r.handle = '0; r.queue = '0;
            due_q.push_back(r);
            return;
          end
          sweep_pos = top_q;
          sweep_flr--;
          if (sweep_flr < 0) sweep_flr = top_q;
          if (sweep_flr <= 0) last = 1;
        end
        if (busy_queue(sweep_pos)) break;
      end
      r.found  = 1'b1;
      r.handle = head_q[sweep_pos][PW-1:0];
      r.queue  = sweep_pos[QW-1:0];
      head_q[sweep_pos] = next_h[r.handle];
      due_q.push_back(r);
      // lower the top mark past queues that are now empty
      while (!busy_queue(sweep_pos) && sweep_pos == top_q && top_q > 0) begin
        top_q--;
        sweep_pos--;
        if (sweep_pos < sweep_flr) sweep_flr = sweep_pos;
      end
    endfunction

    function void check_result(logic found, logic [PW-1:0] h, logic [QW-1:0] q);
      sched_result_t e;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result found=%0d handle=%0d queue=%0d", found, h, q);
        return;
      end
      e = due_q.pop_front();
      if (found !== e.found || h !== e.handle || q !== e.queue) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("result mismatch: exp found=%0d handle=%0d queue=%0d, got %0d %0d %0d",
                   e.found, e.handle, e.queue, found, h, q);
      end
    endfunction
  endclass

  logic clk;
  logic rst_ni;
  int   cycles;
  int   send_idle, recv_idle;   // percent of cycles spent idle
  int   hold_off;               // receiver hold-off, in cycles
  int   rot_handle;
  sched_scoreboard sched_sb;

  mqss_in_if  in_if();
  mqss_out_if out_if();
  mqss_cfg_if cfg_if();

  multilevel_queue_sweep_scheduler_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .res_chan_o (out_if),
    .cfg_chan_i (cfg_if)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // hold-off counter in its own process
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sched_sb.check_result(out_if.found, out_if.out_handle, out_if.queue_index);
    out_if.ready <= (hold_off == 0) && ($urandom_range(99) >= recv_idle);
  end

  // work side: note each accepted transfer
  always @(posedge clk) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sched_sb.note_item(in_if.operation, in_if.item_handle, in_if.move_priority,
                         in_if.cards_out);
  end

  // ready is looked at mid-cycle, so the transfer edge is known without races
  task automatic send_item(logic op, logic [PW-1:0] h, logic signed [MPW-1:0] mp,
                           logic [NW-1:0] n);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.item_handle   <= h;
    in_if.move_priority <= mp;
    in_if.cards_out     <= n;
    forever begin
      @(negedge clk);
      if (in_if.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sched_sb.due_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // valid stays high between back-to-back writes; the caller drops it
  task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_if.ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    sched_sb.write_reg(idx, data);
  endtask

  task automatic set_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c, bit lifo);
    drain();
    write_cfg(CFG_COEF_SQUARE, a);
    write_cfg(CFG_COEF_LINEAR, b);
    write_cfg(CFG_COEF_OFFSET, c);
    write_cfg(CFG_STACK_MODE, {15'd0, lifo});
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly rotating handles so a handle is rarely queued twice
  task automatic random_item();
    logic [PW-1:0]         h;
    logic [NW-1:0]         n;
    logic signed [MPW-1:0] mp;
    logic                  op;
    op = ($urandom_range(99) < 45) ? OP_DEQUEUE : OP_ENQUEUE;
    if ($urandom_range(9) == 0) h = PW'($urandom_range(POOL_ENTRIES - 1));
    else begin
      h = rot_handle[PW-1:0];
      rot_handle = (rot_handle + 1) % POOL_ENTRIES;
    end
    mp = MPW'($urandom_range(255));
    n  = ($urandom_range(9) == 0) ? NW'($urandom_range(63)) : NW'($urandom_range(52));
    send_item(op, h, mp, n);
  endtask

  initial begin
    sched_sb = new();
    sched_sb.clear();
    cycles = 0; hold_off = 0; rot_handle = 0;
    send_idle = 35; recv_idle = 65;
    rst_ni = 1'b0;
    in_if.valid = 1'b0; in_if.operation = OP_ENQUEUE; in_if.item_handle = '0;
    in_if.move_priority = '0; in_if.cards_out = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: empty dequeue, field extremes, both link modes
    set_coefs(16'd0, 16'd0, 16'd0, 1'b0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_ENQUEUE, 10'd0, -8'sd128, 6'd0);
    send_item(OP_ENQUEUE, 10'd1023, 8'sd127, 6'd63);
    send_item(OP_ENQUEUE, 10'd5, 8'sd127, 6'd0);
    send_item(OP_ENQUEUE, 10'd6, 8'sd40, 6'd52);
    send_item(OP_ENQUEUE, 10'd7, 8'sd40, 6'd52);
    send_item(OP_DEQUEUE, 10'd1023, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    set_coefs(16'h0080, 16'hFF80, 16'h0180, 1'b1);
    send_item(OP_ENQUEUE, 10'd9, 8'sd3, 6'd1);
    send_item(OP_ENQUEUE, 10'd10, 8'sd3, 6'd1);
    send_item(OP_ENQUEUE, 10'd11, 8'sd3, 6'd1);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);
    send_item(OP_DEQUEUE, 10'd0, 8'sd0, 6'd0);

    // random: three idle patterns over five coefficient sets
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 35 : (mode == 1) ? 65 : 0;
      recv_idle = (mode == 0) ? 65 : (mode == 1) ? 35 : 0;
      for (int set = 0; set < 5; set++) begin
        case (set)
          0: set_coefs(16'd0, 16'd0, 16'd0, 1'b0);
          1: set_coefs(16'd3, 16'd20, -16'sd300, 1'b1);
          2: set_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
          3: set_coefs(16'h8000, 16'h8000, 16'h8000, 1'b1);
          default: set_coefs(CW'($urandom_range(65535)), CW'($urandom_range(65535)),
                             CW'($urandom_range(65535)), 1'($urandom_range(1)));
        endcase
        if (mode == 2 && set == 0) begin
          // receiver stalls long while items keep coming, so the input backs up
          hold_off = 3000;
          repeat (60) random_item();
        end
        repeat (120) random_item();
      end
    end

    in_if.valid <= 1'b0;
    while (sched_sb.due_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sched_sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
